/* sv/tps_pkg.sv */
// Shared types, codes and helpers for the tile phase scheduler.
// No dependencies; used by every module of the block.
package tps_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TimerW = CountW + 1;
  localparam int unsigned IndexW = 8;

  // Configuration register indexes
  localparam logic [IndexW-1:0] REG_SD_COMP_LEN  = 8'd0;
  localparam logic [IndexW-1:0] REG_SD_DRAIN_LEN = 8'd1;
  localparam logic [IndexW-1:0] REG_SP_COMP_LEN  = 8'd2;
  localparam logic [IndexW-1:0] REG_SP_DRAIN_LEN = 8'd3;
  localparam logic [IndexW-1:0] REG_WORKLOAD     = 8'd4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SD_COMP  = 3'd1,
    PH_SD_DRAIN = 3'd2,
    PH_SP_COMP  = 3'd3,
    PH_SP_DRAIN = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SDDMM = 2'd1,
    MODE_SPMM  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CountW-1:0] sd_comp_len;
    logic [CountW-1:0] sd_drain_len;
    logic [CountW-1:0] sp_comp_len;
    logic [CountW-1:0] sp_drain_len;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [CountW-1:0] tiles;
  } tile_load_t;

  typedef struct packed {
    logic   engine_en;
    mode_t  engine_op;
    logic   tile_clear;
    logic   clear_datapath;
    phase_t phase;
    logic   done_res;
  } result_t;

  // Timer is a two's complement value from -1 upwards; the phase ends once
  // timer >= count - 1, i.e. timer + 1 >= count with -1 + 1 wrapping to 0.
  function automatic logic reached(logic [TimerW-1:0] timer,
                                   logic [CountW-1:0] count);
    logic [TimerW-1:0] t1;
    t1 = timer + TimerW'(1);
    return t1 >= {1'b0, count};
  endfunction

endpackage

/* sv/tps_cfg_regs.sv */
// Configuration register file of the tile phase scheduler.
// Depends on tps_pkg for the register indexes and the cfg_t / tile_load_t types.
module tps_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [tps_pkg::IndexW-1:0]   wr_index,
  input  logic [tps_pkg::CountW-1:0]   wr_data,
  output tps_pkg::cfg_t                cfg,
  output tps_pkg::tile_load_t          tile_load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sd_comp_len  <= tps_pkg::CountW'(1);
      cfg.sd_drain_len <= tps_pkg::CountW'(1);
      cfg.sp_comp_len  <= tps_pkg::CountW'(1);
      cfg.sp_drain_len <= tps_pkg::CountW'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        tps_pkg::REG_SD_COMP_LEN:  cfg.sd_comp_len  <= wr_data;
        tps_pkg::REG_SD_DRAIN_LEN: cfg.sd_drain_len <= wr_data;
        tps_pkg::REG_SP_COMP_LEN:  cfg.sp_comp_len  <= wr_data;
        tps_pkg::REG_SP_DRAIN_LEN: cfg.sp_drain_len <= wr_data;
        default: ;
      endcase
    end
  end

  // Workload writes go straight to the phase core as a reload request
  always_comb begin
    tile_load.load  = wr_en && (wr_index == tps_pkg::REG_WORKLOAD);
    tile_load.tiles = wr_data;
  end

endmodule

/* sv/tps_phase_core.sv */
// Phase state, timer and tile counter, with the next-state and control logic.
// Depends on tps_pkg for phase/mode codes, structs and the reached() compare.
module tps_phase_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  data_ready,
  input  tps_pkg::cfg_t         cfg,
  input  tps_pkg::tile_load_t   tile_load,
  output tps_pkg::result_t      result
);

  tps_pkg::phase_t              phase_reg;
  tps_pkg::phase_t              phase_reg_next;
  logic [tps_pkg::TimerW-1:0]   phase_timer;
  logic [tps_pkg::TimerW-1:0]   phase_timer_next;
  logic [tps_pkg::CountW-1:0]   tiles_left;
  logic [tps_pkg::CountW-1:0]   tiles_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= tps_pkg::PH_IDLE;
      phase_timer <= '0;
      tiles_left  <= '0;
    end else if (tile_load.load) begin
      phase_reg   <= tps_pkg::PH_IDLE;
      phase_timer <= '0;
      tiles_left  <= tile_load.tiles;
    end else if (step) begin
      phase_reg   <= phase_reg_next;
      phase_timer <= phase_timer_next;
      tiles_left  <= tiles_left_next;
    end
  end

  always_comb begin
    logic [tps_pkg::CountW-1:0] tiles_dec;
    tiles_dec = (tiles_left != '0) ? tiles_left - tps_pkg::CountW'(1) : '0;

    phase_reg_next        = phase_reg;
    phase_timer_next      = phase_timer + tps_pkg::TimerW'(1);
    tiles_left_next       = tiles_left;
    result.engine_en      = 1'b1;
    result.engine_op      = tps_pkg::MODE_IDLE;
    result.tile_clear     = 1'b0;
    result.clear_datapath = 1'b0;

    unique case (phase_reg)
      tps_pkg::PH_SD_COMP: begin
        result.engine_op = tps_pkg::MODE_SDDMM;
        if (tps_pkg::reached(phase_timer, cfg.sd_comp_len)) begin
          phase_reg_next   = tps_pkg::PH_SD_DRAIN;
          phase_timer_next = '0;
        end
      end
      tps_pkg::PH_SD_DRAIN: begin
        result.engine_op = tps_pkg::MODE_SDDMM;
        if (tps_pkg::reached(phase_timer, cfg.sd_drain_len)) begin
          phase_reg_next        = tps_pkg::PH_SP_COMP;
          phase_timer_next      = '1;
          result.engine_op      = tps_pkg::MODE_SPMM;
          result.clear_datapath = 1'b1;
        end
      end
      tps_pkg::PH_SP_COMP: begin
        result.engine_op = tps_pkg::MODE_SPMM;
        if (tps_pkg::reached(phase_timer, cfg.sp_comp_len)) begin
          phase_reg_next   = tps_pkg::PH_SP_DRAIN;
          phase_timer_next = '0;
        end
      end
      tps_pkg::PH_SP_DRAIN: begin
        result.engine_op = tps_pkg::MODE_SPMM;
        if (tps_pkg::reached(phase_timer, cfg.sp_drain_len)) begin
          tiles_left_next = tiles_dec;
          if ((tiles_dec != '0) && data_ready) begin
            phase_reg_next    = tps_pkg::PH_SD_COMP;
            phase_timer_next  = '1;
            result.engine_op  = tps_pkg::MODE_SDDMM;
            result.tile_clear = 1'b1;
          end else begin
            phase_reg_next   = tps_pkg::PH_IDLE;
            phase_timer_next = '0;
            result.engine_en = 1'b0;
            result.engine_op = tps_pkg::MODE_IDLE;
          end
        end
      end
      default: begin
        // idle, and any code that cannot be reached
        phase_reg_next   = tps_pkg::PH_IDLE;
        phase_timer_next = '0;
        result.engine_en = 1'b0;
        if ((tiles_left != '0) && data_ready) begin
          phase_reg_next    = tps_pkg::PH_SD_COMP;
          phase_timer_next  = '1;
          result.engine_en  = 1'b1;
          result.engine_op  = tps_pkg::MODE_SDDMM;
          result.tile_clear = 1'b1;
        end
      end
    endcase

    result.phase    = phase_reg_next;
    result.done_res = (tiles_left_next == '0) && (phase_reg_next == tps_pkg::PH_IDLE);
  end

endmodule

/* sv/tile_phase_scheduler_unit.sv */
// Tile phase scheduler top: steps tiles through idle, SDDMM compute/drain and
// SPMM compute/drain, one tick per input transfer; built on tps_pkg.
// The result of each input transfer is registered in the output register.
// Throughput: one tick per cycle while the sink does not stall; phase state and
// output register load on the same edge, so ticks follow back to back.
// Reset (rst, synchronous): idle, timer and tiles zero, counts one, no result.
module tile_phase_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  // tick input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        data_ready,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        engine_en,
  output logic [1:0]                  engine_op,
  output logic                        tile_clear,
  output logic                        clear_datapath,
  output logic [2:0]                  phase,
  output logic                        done_res,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tps_pkg::IndexW-1:0]  cfg_index,
  input  logic [tps_pkg::CountW-1:0]  cfg_data
);

  tps_pkg::cfg_t        cfg;
  tps_pkg::tile_load_t  tile_load;
  tps_pkg::result_t     step_result;
  logic                 in_xfer;
  logic                 out_xfer;

  // Writes always taken; user writes only while block is quiet; not enforced
  assign cfg_ready = 1'b1;

  // Hold the input only while a finished result waits and the sink is stalling
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  tps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .tile_load (tile_load)
  );

  // Advance the phase state once per accepted tick
  tps_phase_core u_phase_core (
    .clk        (clk),
    .rst        (rst),
    .step       (in_xfer),
    .data_ready (data_ready),
    .cfg        (cfg),
    .tile_load  (tile_load),
    .result     (step_result)
  );

  // Output register: valid flag under reset, payload loads on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      engine_en      <= step_result.engine_en;
      engine_op      <= step_result.engine_op;
      tile_clear     <= step_result.tile_clear;
      clear_datapath <= step_result.clear_datapath;
      phase          <= step_result.phase;
      done_res       <= step_result.done_res;
    end
  end

endmodule
